// ===== src/lnc_pkg.sv =====
// Shared types and constants for the LFSR noise channel.
// No dependencies; used by the request interface and the top level.
package lnc_pkg;

	localparam int unsigned NUM_REGS = 5;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned PERIOD_W = 22;
	localparam int unsigned SHIFT_W = 15;
	localparam int unsigned LEN_W = 7;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 15'h7FFF;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 22'd8;
	localparam logic [LEN_W-1:0] LEN_FULL = 7'd64;
	localparam logic [3:0] VOL_RESET = 4'd15;
	localparam logic [3:0] VOL_MAX = 4'd15;

	// Event codes carried in the func field.
	typedef enum logic [2:0] {
		FUNC_READ  = 3'd0,
		FUNC_WRITE = 3'd1,
		FUNC_FREQ  = 3'd2,
		FUNC_LEN   = 3'd3,
		FUNC_ENV   = 3'd4
	} func_t;

	// Channel register offsets.
	localparam logic [REG_IDX_W-1:0] REG_LEN  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ENV  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FREQ = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CTRL = 3'd4;

	// Noise period in ticks: 16*d*2^s for a nonzero divisor, else 8*2^s.
	function automatic logic [PERIOD_W-1:0] period_of(input logic [7:0] freq_reg);
		logic [2:0] div;
		logic [3:0] sh;
		div = freq_reg[2:0];
		sh = freq_reg[7:4];
		if (div != 3'd0)
			return {15'd0, div, 4'd0} << sh;
		return PERIOD_RESET << sh;
	endfunction

endpackage

// ===== src/lnc_if.sv =====
// Valid/ready channels of the noise channel: event requests and results.
// Depends on lnc_pkg for field widths.
interface lnc_req_if import lnc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           func;
	logic [REG_IDX_W-1:0] reg_index;
	logic [7:0]           write_data;

	modport source (output valid, func, reg_index, write_data, input ready);
	modport sink (input valid, func, reg_index, write_data, output ready);
endinterface

interface lnc_rsp_if;
	logic              valid;
	logic              ready;
	logic [7:0]        read_data;
	logic              channel_active;
	logic signed [4:0] amplitude;

	modport source (output valid, read_data, channel_active, amplitude, input ready);
	modport sink (input valid, read_data, channel_active, amplitude, output ready);
endinterface

// ===== src/lfsr_noise_channel.sv =====
// Noise sound channel: 15-bit LFSR, length counter and volume envelope.
// Depends on lnc_pkg and the channel interfaces in lnc_if.sv.
//
// Usage: every beat on req is one event (register read or write, frequency
// tick, length tick or envelope tick) and yields exactly one beat on rsp,
// carrying the read byte, the active flag and the signed amplitude as they
// stand after the event has been applied.
// An accepted event waits in the request register until its result has
// room, and its result is then registered in the result register, where
// it can be taken. The channel state is updated in the same cycle the
// result is registered.
// Throughput is one event per cycle while the receiver takes each result,
// set by the single pass of logic between the two registers.
// When the receiver stalls, the result register holds its beat and the
// request register keeps one further event; req.ready drops only when both
// are occupied, and no event is applied until its result has room.
// Reset clears both pipeline valid flags and puts the channel state into
// its power-on values: registers zero, volume 15 rising, period 8, LFSR all
// ones, channel on.
module lfsr_noise_channel import lnc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	lnc_req_if.sink   req,
	lnc_rsp_if.source rsp
);

	logic                 valid_s1;
	logic [2:0]           func_s1;
	logic [REG_IDX_W-1:0] idx_s1;
	logic [7:0]           data_s1;

	logic              valid_s2;
	logic [7:0]        read_data_s2;
	logic              active_s2;
	logic signed [4:0] amp_s2;

	logic [7:0]          regs_q [NUM_REGS];
	logic [LEN_W-1:0]    len_q;
	logic [2:0]          env_cnt_q;
	logic [3:0]          vol_q;
	logic                env_up_q;
	logic [PERIOD_W-1:0] period_q;
	logic [SHIFT_W-1:0]  shift_q;
	logic                on_q;

	logic [7:0]          regs_d [NUM_REGS];
	logic [LEN_W-1:0]    len_d;
	logic [2:0]          env_cnt_d;
	logic [3:0]          vol_d;
	logic                env_up_d;
	logic [PERIOD_W-1:0] period_d;
	logic [SHIFT_W-1:0]  shift_d;
	logic                on_d;
	logic [7:0]          rd;
	logic                active;
	logic signed [4:0]   amp;
	logic [PERIOD_W-1:0] period_dec;
	logic [2:0]          env_dec;
	logic                fb;

	logic advance;

	assign advance = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_comb begin
		regs_d = regs_q;
		len_d = len_q;
		env_cnt_d = env_cnt_q;
		vol_d = vol_q;
		env_up_d = env_up_q;
		period_d = period_q;
		shift_d = shift_q;
		on_d = on_q;
		rd = 8'd0;
		period_dec = period_q - 22'd1;
		env_dec = env_cnt_q - 3'd1;
		fb = shift_q[0] ^ shift_q[1];

		case (func_s1)
			FUNC_READ: begin
				if (idx_s1 < REG_IDX_W'(NUM_REGS))
					rd = regs_q[idx_s1];
			end
			FUNC_WRITE: begin
				if (idx_s1 < REG_IDX_W'(NUM_REGS)) begin
					regs_d[idx_s1] = data_s1;
					case (idx_s1)
						REG_LEN: begin
							len_d = LEN_FULL - {1'b0, data_s1[5:0]};
						end
						REG_ENV: begin
							vol_d = data_s1[7:4];
							env_up_d = data_s1[3];
							env_cnt_d = data_s1[2:0];
						end
						REG_CTRL: begin
							// Trigger restarts the channel from the stored settings.
							if (data_s1[7]) begin
								on_d = 1'b1;
								if (len_q == '0)
									len_d = LEN_FULL - {1'b0, regs_q[REG_LEN][5:0]};
								period_d = period_of(regs_q[REG_FREQ]);
								env_cnt_d = regs_q[REG_ENV][2:0];
								vol_d = regs_q[REG_ENV][7:4];
								shift_d = SHIFT_RESET;
							end
						end
						default: begin
						end
					endcase
				end
			end
			FUNC_FREQ: begin
				if (period_dec == '0) begin
					period_d = period_of(regs_q[REG_FREQ]);
					shift_d = {fb, shift_q[SHIFT_W-1:1]};
					// Narrow mode feeds the same bit back into bit 6 as well.
					if (regs_q[REG_FREQ][3])
						shift_d[6] = fb;
				end else begin
					period_d = period_dec;
				end
			end
			FUNC_LEN: begin
				if (regs_q[REG_CTRL][6] && len_q != '0) begin
					len_d = len_q - 7'd1;
					if (len_d == '0)
						on_d = 1'b0;
				end
			end
			FUNC_ENV: begin
				if (regs_q[REG_ENV][2:0] != 3'd0) begin
					if (env_dec == 3'd0) begin
						env_cnt_d = regs_q[REG_ENV][2:0];
						if (env_up_q && vol_q < VOL_MAX)
							vol_d = vol_q + 4'd1;
						else if (!env_up_q && vol_q > 4'd0)
							vol_d = vol_q - 4'd1;
					end else begin
						env_cnt_d = env_dec;
					end
				end
			end
			default: begin
			end
		endcase

		active = (regs_d[REG_ENV][7:3] != 5'd0) && on_d;
		amp = shift_d[0] ? -$signed({1'b0, vol_d}) : $signed({1'b0, vol_d});
	end

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			func_s1 <= req.func;
			idx_s1 <= req.reg_index;
			data_s1 <= req.write_data;
		end
	end

	// Channel state, committed as the event moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				regs_q[i] <= 8'd0;
			len_q <= '0;
			env_cnt_q <= 3'd0;
			vol_q <= VOL_RESET;
			env_up_q <= 1'b1;
			period_q <= PERIOD_RESET;
			shift_q <= SHIFT_RESET;
			on_q <= 1'b1;
		end else if (advance) begin
			regs_q <= regs_d;
			len_q <= len_d;
			env_cnt_q <= env_cnt_d;
			vol_q <= vol_d;
			env_up_q <= env_up_d;
			period_q <= period_d;
			shift_q <= shift_d;
			on_q <= on_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= rd;
			active_s2 <= active;
			amp_s2 <= amp;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.read_data = read_data_s2;
	assign rsp.channel_active = active_s2;
	assign rsp.amplitude = amp_s2;

endmodule
